FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers with synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// antecedent implies consequent at the next clock edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/wsfu_pkg.sv
// ----------------------------------------------------------------------------
// wsfu_pkg
// Types and constants shared by the frame unmask unit.
// ----------------------------------------------------------------------------
package wsfu_pkg;

    typedef enum logic [2:0] {
        PH_FIRST = 3'd0,
        PH_LEN   = 3'd1,
        PH_EXT   = 3'd2,
        PH_MASK  = 3'd3,
        PH_DATA  = 3'd4
    } t_phase;

    localparam logic [1:0] ST_PAYLOAD  = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_BAD_HDR  = 2'd2;
    localparam logic [1:0] ST_OVERSIZE = 2'd3;

    localparam logic [7:0]  HDR_FIN_TEXT    = 8'd129;
    localparam logic [6:0]  LEN_DIRECT_MAX  = 7'd125;
    localparam logic [6:0]  LEN_EXT16       = 7'd126;
    localparam logic [2:0]  EXT16_BYTES     = 3'd2;
    localparam logic [2:0]  EXT64_BYTES     = 3'd0;  // eight bytes, counted mod 8
    localparam logic [15:0] MAX_PAYLOAD_RST = 16'd5120;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       last_byte;
        logic [1:0] status;
    } t_result;

endpackage

FILE: hw/rtl/wsfu_parser.sv
// ----------------------------------------------------------------------------
// wsfu_parser
// Frame header state machine and payload unmasking, one byte per transfer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wsfu_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_rx_byte,
    input  logic [15:0]          i_max_payload,
    output logic                 o_emit,
    output wsfu_pkg::t_result    o_result
);

    wsfu_pkg::t_phase r_phase, n_phase;
    logic [2:0]  r_hdr_cnt, n_hdr_cnt;
    logic [15:0] r_flen, n_flen;     // low 16 bits of frame length
    logic        r_fovf, n_fovf;     // frame length has bits above 16
    logic [31:0] r_key, n_key;
    logic [15:0] r_left, n_left;
    logic [1:0]  r_idx, n_idx;

    always_comb begin
        logic       len_done;
        logic [7:0] key_b;
        n_phase   = r_phase;
        n_hdr_cnt = r_hdr_cnt;
        n_flen    = r_flen;
        n_fovf    = r_fovf;
        n_key     = r_key;
        n_left    = r_left;
        n_idx     = r_idx;
        len_done  = 1'b0;
        o_emit    = 1'b0;
        o_result  = '0;
        key_b     = 8'(r_key >> {~r_idx, 3'b000});
        unique case (r_phase)
            wsfu_pkg::PH_LEN: begin
                n_fovf = 1'b0;
                if (i_rx_byte[6:0] <= wsfu_pkg::LEN_DIRECT_MAX) begin
                    n_flen   = {9'd0, i_rx_byte[6:0]};
                    len_done = 1'b1;
                end else begin
                    n_flen    = '0;
                    n_hdr_cnt = (i_rx_byte[6:0] == wsfu_pkg::LEN_EXT16) ?
                                wsfu_pkg::EXT16_BYTES : wsfu_pkg::EXT64_BYTES;
                    n_phase   = wsfu_pkg::PH_EXT;
                end
            end
            wsfu_pkg::PH_EXT: begin
                n_fovf    = r_fovf | (r_flen[15:8] != 8'd0);
                n_flen    = {r_flen[7:0], i_rx_byte};
                n_hdr_cnt = r_hdr_cnt - 3'd1;
                len_done  = (n_hdr_cnt == 3'd0);
            end
            wsfu_pkg::PH_MASK: begin
                n_key     = {r_key[23:0], i_rx_byte};
                n_hdr_cnt = r_hdr_cnt + 3'd1;
                if (n_hdr_cnt[2]) begin
                    n_hdr_cnt = '0;
                    if (r_flen == 16'd0) begin
                        n_phase                = wsfu_pkg::PH_FIRST;
                        o_emit                 = 1'b1;
                        o_result.last_byte     = 1'b1;
                        o_result.status        = wsfu_pkg::ST_EMPTY;
                    end else begin
                        n_left  = r_flen;
                        n_idx   = '0;
                        n_phase = wsfu_pkg::PH_DATA;
                    end
                end
            end
            wsfu_pkg::PH_DATA: begin
                n_idx                 = r_idx + 2'd1;
                n_left                = r_left - 16'd1;
                o_emit                = 1'b1;
                o_result.payload_byte = i_rx_byte ^ key_b;
                o_result.status       = wsfu_pkg::ST_PAYLOAD;
                if (n_left == 16'd0) begin
                    n_phase            = wsfu_pkg::PH_FIRST;
                    o_result.last_byte = 1'b1;
                end
            end
            default: begin
                n_phase = wsfu_pkg::PH_FIRST;
                if (i_rx_byte != wsfu_pkg::HDR_FIN_TEXT) begin
                    o_emit          = 1'b1;
                    o_result.status = wsfu_pkg::ST_BAD_HDR;
                end else begin
                    n_phase = wsfu_pkg::PH_LEN;
                end
            end
        endcase
        if (len_done) begin
            if (n_fovf || (n_flen > i_max_payload)) begin
                n_phase         = wsfu_pkg::PH_FIRST;
                o_emit          = 1'b1;
                o_result.status = wsfu_pkg::ST_OVERSIZE;
            end else begin
                n_phase   = wsfu_pkg::PH_MASK;
                n_hdr_cnt = '0;
                n_key     = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= wsfu_pkg::PH_FIRST;
            r_hdr_cnt <= '0;
            r_flen    <= '0;
            r_fovf    <= 1'b0;
            r_key     <= '0;
            r_left    <= '0;
            r_idx     <= '0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_flen    <= n_flen;
            r_fovf    <= n_fovf;
            r_key     <= n_key;
            r_left    <= n_left;
            r_idx     <= n_idx;
        end
    end

    `ASSERT_ALWAYS(a_data_has_bytes, i_clk, i_rst_n, (r_phase != wsfu_pkg::PH_DATA) || (r_left != 16'd0))
    `ASSERT_ALWAYS(a_payload_in_data, i_clk, i_rst_n, !(o_emit && o_result.status == wsfu_pkg::ST_PAYLOAD) || (r_phase == wsfu_pkg::PH_DATA))
    `ASSERT_NEXT(a_emit_not_data_ends, i_clk, i_rst_n, i_accept && o_emit && (o_result.status != wsfu_pkg::ST_PAYLOAD), r_phase == wsfu_pkg::PH_FIRST)

endmodule

FILE: hw/rtl/wsfu_out_reg.sv
// ----------------------------------------------------------------------------
// wsfu_out_reg
// Result register; takes a new result in the cycle the old one is taken.
// ----------------------------------------------------------------------------
module wsfu_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  wsfu_pkg::t_result i_result,
    output logic              o_valid,
    input  logic              i_ready,
    output wsfu_pkg::t_result o_result
);

    logic              r_valid;
    wsfu_pkg::t_result r_result;

    assign o_ready  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= i_result;
        end
    end

endmodule

FILE: hw/rtl/websocket_frame_unmask_unit.sv
// Output: a result is registered and appears on the output in the cycle after its byte transfer.
// Throughput: one byte per cycle while the result register is free or taken;
// parser state moves per byte; the register frees in the cycle it is taken.
// Reset: synchronous, active low; parser returns to the first-byte phase and
// max_payload returns to 5120. No clearing pass.
// ----------------------------------------------------------------------------
// websocket_frame_unmask_unit
// Client frame header decode and payload unmasking, one byte per transfer.
// ----------------------------------------------------------------------------
module websocket_frame_unmask_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_payload_byte,
    output logic        o_last_byte,
    output logic [1:0]  o_status
);

    logic [15:0]       r_max_payload;
    logic              accept;
    logic              emit;
    logic              slot_ready;
    wsfu_pkg::t_result res;
    wsfu_pkg::t_result out_res;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = slot_ready;
    assign accept      = i_valid && slot_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= wsfu_pkg::MAX_PAYLOAD_RST;
        end else if (i_cfg_valid) begin
            r_max_payload <= i_cfg_data;
        end
    end

    wsfu_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_rx_byte     (i_rx_byte),
        .i_max_payload (r_max_payload),
        .o_emit        (emit),
        .o_result      (res)
    );

    wsfu_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (accept && emit),
        .o_ready  (slot_ready),
        .i_result (res),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (out_res)
    );

    assign o_payload_byte = out_res.payload_byte;
    assign o_last_byte    = out_res.last_byte;
    assign o_status       = out_res.status;

endmodule
